FILE: src/priority_ordered_handle_list_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the priority-ordered handle list.
// Each use expands to one labeled concurrent assertion on clk, gated by rst.
// ---------------------------------------------------------------------------
`ifndef PRIORITY_ORDERED_HANDLE_LIST_ASSERT_SVH
`define PRIORITY_ORDERED_HANDLE_LIST_ASSERT_SVH

// Invariant that holds at every clock edge out of reset.
`define POHL_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define POHL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: src/pohl_pkg.sv
// ---------------------------------------------------------------------------
// pohl_pkg
// Request/response types and codes for the priority-ordered handle list.
// ---------------------------------------------------------------------------
package pohl_pkg;

  // Action codes
  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_FIND   = 2'd2;
  localparam logic [1:0] ACT_READ   = 2'd3;

  // Status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NULL     = 3'd1;
  localparam logic [2:0] ST_DUP      = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  // One stored entry: handle in the upper half, priority in the lower half
  localparam int HANDLE_W = 32;
  localparam int PRIO_W   = 32;
  localparam int WORD_W   = HANDLE_W + PRIO_W;

  typedef struct packed {
    logic [1:0]         action;
    logic [31:0]        handle;
    logic signed [31:0] priority_req;
    logic [4:0]         slot_index;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               present;
    logic [5:0]         entry_count;
    logic               slot_valid;
    logic [31:0]        slot_handle;
    logic signed [31:0] slot_priority;
  } rsp_t;

endpackage

FILE: src/pohl_ram.sv
// ---------------------------------------------------------------------------
// pohl_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module pohl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/priority_ordered_handle_list.sv
// ---------------------------------------------------------------------------
// priority_ordered_handle_list
// List of nonzero handles kept in descending priority order in one RAM.
// ---------------------------------------------------------------------------
// Usage:
//   A request (req, req_valid/req_ready) carries an action: add, remove,
//   find or read slot. Each request yields exactly one response
//   (rsp, rsp_valid/rsp_ready) with status, presence and entry count.
//   One request is in flight at a time; req_ready is high only when idle.
//   After a request is accepted, the entry RAM is scanned once to locate
//   the handle and the insertion point, a decision step follows, then an
//   add or remove moves the entries behind the target one per cycle
//   through the RAM's single read and write port, and an add writes the
//   new entry. The response sits in an output register; while the
//   receiver stalls, the next request is accepted and processed and
//   waits in its last step.
//   Reset (rst, synchronous) empties the list at once; the RAM is not
//   cleared since only entries below the count are ever read.
// ---------------------------------------------------------------------------
`include "priority_ordered_handle_list_assert.svh"

module priority_ordered_handle_list #(
  parameter int MAX_ENTRIES = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  pohl_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output pohl_pkg::rsp_t rsp
);

  localparam int AW   = $clog2(MAX_ENTRIES);
  localparam int CW   = $clog2(MAX_ENTRIES + 1);
  localparam int CMPW = (CW > 5) ? CW : 5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_INSERT,
    S_SLOT,
    S_RESP
  } state_t;

  state_t         state;
  logic [CW-1:0]  cnt;
  pohl_pkg::req_t r;
  pohl_pkg::rsp_t res;

  // scan bookkeeping
  logic [CW-1:0]  ptr;
  logic           pend;
  logic [AW-1:0]  paddr;
  logic           found;
  logic [AW-1:0]  pos;
  logic           at_found;
  logic [CW-1:0]  at;

  // shift bookkeeping
  logic [CW-1:0]  rp;
  logic [CW-1:0]  rem;
  logic           dir_down;
  logic [AW-1:0]  wq;

  // RAM port signals
  logic                       rd_en;
  logic [AW-1:0]              rd_addr;
  logic [pohl_pkg::WORD_W-1:0] rd_data;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [pohl_pkg::WORD_W-1:0] wr_data;

  logic [31:0]        rd_handle;
  logic signed [31:0] rd_prio;
  logic               slot_ok;
  logic               hit_present;

  assign rd_handle   = rd_data[pohl_pkg::WORD_W-1:pohl_pkg::PRIO_W];
  assign rd_prio     = $signed(rd_data[pohl_pkg::PRIO_W-1:0]);
  assign slot_ok     = CMPW'(r.slot_index) < CMPW'(cnt);
  assign hit_present = found && (r.handle != '0);
  assign req_ready   = (state == S_IDLE);

  // Entry storage
  pohl_ram #(
    .WIDTH(pohl_pkg::WORD_W),
    .DEPTH(MAX_ENTRIES)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // RAM access per state
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ptr[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = wq;
    wr_data = rd_data;
    case (state)
      S_SCAN: begin
        rd_en = (ptr < cnt);
      end
      S_DECIDE: begin
        rd_en   = (r.action == pohl_pkg::ACT_READ) && slot_ok;
        rd_addr = AW'(r.slot_index);
      end
      S_SHIFT: begin
        rd_en   = (rem != '0);
        rd_addr = rp[AW-1:0];
        wr_en   = pend;
      end
      S_INSERT: begin
        wr_en   = 1'b1;
        wr_addr = at[AW-1:0];
        wr_data = {r.handle, r.priority_req};
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            r        <= req;
            ptr      <= '0;
            pend     <= 1'b0;
            found    <= 1'b0;
            at_found <= 1'b0;
            at       <= cnt;
            state    <= S_SCAN;
          end
        end

        // Walk all stored entries: first handle match and first lower priority
        S_SCAN: begin
          if (ptr < cnt) begin
            ptr <= ptr + 1'b1;
          end
          pend  <= (ptr < cnt);
          paddr <= ptr[AW-1:0];
          if (pend) begin
            if (!found && (rd_handle == r.handle)) begin
              found <= 1'b1;
              pos   <= paddr;
            end
            if (!at_found && (r.priority_req > rd_prio)) begin
              at_found <= 1'b1;
              at       <= CW'(paddr);
            end
          end
          if (!(ptr < cnt) && !pend) begin
            state <= S_DECIDE;
          end
        end

        S_DECIDE: begin
          res.status        <= pohl_pkg::ST_OK;
          res.present       <= hit_present;
          res.entry_count   <= '0;
          res.slot_valid    <= 1'b0;
          res.slot_handle   <= '0;
          res.slot_priority <= '0;
          pend              <= 1'b0;
          state             <= S_RESP;
          case (r.action)
            pohl_pkg::ACT_ADD: begin
              if (r.handle == '0) begin
                res.status <= pohl_pkg::ST_NULL;
              end else if (hit_present) begin
                res.status <= pohl_pkg::ST_DUP;
              end else if (cnt == CW'(MAX_ENTRIES)) begin
                res.status <= pohl_pkg::ST_FULL;
              end else if (at == cnt) begin
                state <= S_INSERT;
              end else begin
                // move entries at..cnt-1 down by one, last first
                rp       <= cnt - 1'b1;
                rem      <= cnt - at;
                dir_down <= 1'b1;
                state    <= S_SHIFT;
              end
            end
            pohl_pkg::ACT_REMOVE: begin
              if (!hit_present) begin
                res.status <= pohl_pkg::ST_NOTFOUND;
              end else begin
                // move entries pos+1..cnt-1 up by one, first first
                rp       <= CW'(pos) + 1'b1;
                rem      <= cnt - CW'(pos) - 1'b1;
                dir_down <= 1'b0;
                state    <= S_SHIFT;
              end
            end
            pohl_pkg::ACT_READ: begin
              if (slot_ok) begin
                state <= S_SLOT;
              end
            end
            default: begin
            end
          endcase
        end

        // One read issued and one write retired per cycle
        S_SHIFT: begin
          if (rem != '0) begin
            rp   <= dir_down ? (rp - 1'b1) : (rp + 1'b1);
            rem  <= rem - 1'b1;
            wq   <= dir_down ? AW'(rp + 1'b1) : AW'(rp - 1'b1);
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if ((rem == '0) && !pend) begin
            if (dir_down) begin
              state <= S_INSERT;
            end else begin
              cnt   <= cnt - 1'b1;
              state <= S_RESP;
            end
          end
        end

        S_INSERT: begin
          cnt   <= cnt + 1'b1;
          state <= S_RESP;
        end

        S_SLOT: begin
          res.slot_valid    <= 1'b1;
          res.slot_handle   <= rd_handle;
          res.slot_priority <= rd_prio;
          state             <= S_RESP;
        end

        // Hand the response to the output register once it is free
        S_RESP: begin
          if (!rsp_valid || rsp_ready) begin
            rsp       <= '{status:        res.status,
                           present:       res.present,
                           entry_count:   6'(cnt),
                           slot_valid:    res.slot_valid,
                           slot_handle:   res.slot_handle,
                           slot_priority: res.slot_priority};
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  `POHL_ASSERT(a_cnt_max, cnt <= CW'(MAX_ENTRIES), "entry count above capacity")
  `POHL_ASSERT_IMP(a_wr_state, wr_en, (state == S_SHIFT) || (state == S_INSERT), "stray RAM write")
  `POHL_ASSERT_IMP(a_wr_range, wr_en, CW'(wr_addr) <= cnt, "RAM write beyond list end")
  `POHL_ASSERT_IMP(a_scan_range, (state == S_SCAN) && pend, CW'(paddr) < cnt, "scan past count")

endmodule
